// ----- design/trrgb_pkg.sv -----
package trrgb_pkg;

    // Sample width default and limits of the log unit
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int LEVEL_W         = 8;

    // Fixed-point log2: Q30 mantissa, 28 fraction bits
    localparam int FRAC_BITS   = 28;
    localparam int M_W         = 31;
    localparam int SAT_RATIO   = 10000;
    localparam int SAT_RATIO_W = 14;

    // ln2 in Q32, T0 in hundredths of a kelvin
    localparam logic [31:0] LN2_Q32       = 32'd2977044472;
    localparam logic [14:0] T0_HUND       = 15'd29815;
    localparam int          KELVIN_OFFSET = 27315;

    // Beta equation: kelvin*100 = NUMER / (BASE_DEN +/- T0*ln)
    localparam int DEN_W = 48;
    localparam int N_W   = 62;
    localparam int Q_W   = 18;
    localparam logic [DEN_W-1:0] BASE_DEN = DEN_W'(64'd419000 << FRAC_BITS);
    localparam logic [N_W-1:0]   NUMER    = N_W'(64'd12492485000 << FRAC_BITS);

    // Result format
    localparam int TEMP_W = 17;
    localparam logic signed [TEMP_W-1:0] TEMP_SAT_HI = 17'sd65535;
    localparam logic signed [TEMP_W-1:0] TEMP_ZERO_K = -17'sd27315;

    // Configuration port
    localparam int DATA_W    = 32;
    localparam int APB_AW    = 5;
    localparam int CFG_N     = 6;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DEPTH = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_MIN   = 3'd0,
        REG_RED_MAX   = 3'd1,
        REG_GREEN_MIN = 3'd2,
        REG_GREEN_MAX = 3'd3,
        REG_BLUE_MIN  = 3'd4,
        REG_BLUE_MAX  = 3'd5
    } cfg_idx_t;

    // All six limits as one row, register index i at slice i
    typedef logic [CFG_N-1:0][CFG_W-1:0] cfg_row_t;

    localparam cfg_row_t CFG_RESET_ROW =
        {16'd0, 16'd100, 16'd0, 16'd100, 16'd0, 16'd100};

    // One squaring step of the log2 fraction: {fraction bit, new mantissa}
    function automatic logic [M_W:0] sq_step(input logic [M_W-1:0] m);
        logic [2*M_W-1:0] sq;
        logic [M_W:0]     t;
        sq = {{M_W{1'b0}}, m} * {{M_W{1'b0}}, m};
        t  = sq[M_W-1 +: M_W+1];
        if (t[M_W]) begin
            return {1'b1, t[M_W:1]};
        end
        return {1'b0, t[M_W-1:0]};
    endfunction

endpackage

// ----- design/trrgb_ram.sv -----
module trrgb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port, registered read (old data on a same-address write)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/trrgb_cfg.sv -----
module trrgb_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trrgb_pkg::APB_AW-1:0]  paddr,
    input  logic [trrgb_pkg::DATA_W-1:0]  pwdata,
    output logic [trrgb_pkg::DATA_W-1:0]  prdata,
    output trrgb_pkg::cfg_row_t           limits
);
    import trrgb_pkg::*;

    logic [CFG_IDX_W-1:0] idx;
    logic                 hit;
    logic                 wr;
    cfg_row_t             rd_data;
    cfg_row_t             row_live;
    cfg_row_t             row_next;
    cfg_row_t             last_row_reg;
    logic                 fwd_reg, fwd_next;
    logic                 valid_reg, valid_next;

    assign idx = paddr[APB_AW-1:2];
    assign hit = (idx <= CFG_IDX_W'(REG_BLUE_MAX));
    assign wr  = psel && penable && pwrite;

    // live row: reset values until first write, last write forwarded
    always_comb begin
        if (!valid_reg) begin
            row_live = CFG_RESET_ROW;
        end else if (fwd_reg) begin
            row_live = last_row_reg;
        end else begin
            row_live = rd_data;
        end
    end

    // read-modify-write of the one row
    always_comb begin
        row_next = row_live;
        if (wr && hit) begin
            row_next[idx] = pwdata[CFG_W-1:0];
        end
        fwd_next   = wr && hit;
        valid_next = valid_reg || (wr && hit);
    end

    trrgb_ram #(
        .WIDTH ($bits(cfg_row_t)),
        .DEPTH (CFG_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr && hit),
        .waddr ('0),
        .wdata (row_next),
        .raddr ('0),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            fwd_reg   <= fwd_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_row_reg <= row_next;
    end

    // read back, sign-extended
    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = {{(DATA_W-CFG_W){row_live[idx][CFG_W-1]}}, row_live[idx]};
        end
    end

    assign limits = row_live;

endmodule

// ----- design/trrgb_temp.sv -----
module trrgb_temp #(
    parameter int SAMPLE_BITS = trrgb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [SAMPLE_BITS-1:0]        raw,
    input  logic [trrgb_pkg::LEVEL_W-1:0] tag_in,
    output logic                          out_valid,
    output logic [trrgb_pkg::TEMP_W-1:0]  temp_out,
    output logic [trrgb_pkg::LEVEL_W-1:0] tag_out
);
    import trrgb_pkg::*;

    localparam int NUM_W  = (SAMPLE_BITS > SAT_RATIO_W) ? SAMPLE_BITS : SAT_RATIO_W;
    localparam int PW     = $clog2(NUM_W);
    localparam int LOG_W  = PW + FRAC_BITS;
    localparam int NL     = FRAC_BITS;
    localparam int S_D    = NL + 1;
    localparam int S_L    = NL + 2;
    localparam int S_E    = NL + 3;
    localparam int S_DIV0 = NL + 4;
    localparam int LAT    = S_DIV0 + Q_W + 2;
    localparam logic [SAMPLE_BITS-1:0] FULL = '1;

    function automatic logic [PW-1:0] msb_of(input logic [NUM_W-1:0] x);
        logic [PW-1:0] p;
        p = '0;
        for (int b = 0; b < NUM_W; b++) begin
            if (x[b]) begin
                p = PW'(b);
            end
        end
        return p;
    endfunction

    // divider ratio and normalisation, straight off the input beat
    logic [NUM_W-1:0] num_next, den_next;
    logic [PW-1:0]    pn_next, pd_next;
    logic [M_W-1:0]   mn_next, md_next;

    always_comb begin
        if (raw == FULL) begin
            num_next = NUM_W'(SAT_RATIO);
            den_next = NUM_W'(1);
        end else begin
            num_next = NUM_W'(raw);
            den_next = NUM_W'(FULL - raw);
        end
        pn_next = msb_of(num_next);
        pd_next = msb_of(den_next);
        mn_next = M_W'(num_next) << (M_W - 1 - int'(pn_next));
        md_next = M_W'(den_next) << (M_W - 1 - int'(pd_next));
    end

    // sideband line: valid, zero-sample flag and level
    logic                 v_reg    [0:LAT-1];
    logic [LEVEL_W:0]     side_reg [0:LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < LAT; s++) begin
                v_reg[s] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < LAT; s++) begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= {(raw == '0), tag_in};
            for (int s = 1; s < LAT; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // log2 by repeated squaring, one fraction bit per stage
    logic [M_W-1:0]   mn_reg [0:NL];
    logic [M_W-1:0]   md_reg [0:NL];
    logic [LOG_W-1:0] rn_reg [0:NL];
    logic [LOG_W-1:0] rd_reg [0:NL];
    logic [M_W:0]     sn_next [0:NL-1];
    logic [M_W:0]     sd_next [0:NL-1];
    logic [LOG_W-1:0] rn_next [0:NL-1];
    logic [LOG_W-1:0] rd_next [0:NL-1];

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            sn_next[i] = sq_step(mn_reg[i]);
            sd_next[i] = sq_step(md_reg[i]);
            rn_next[i] = rn_reg[i] | (LOG_W'(sn_next[i][M_W]) << (FRAC_BITS - 1 - i));
            rd_next[i] = rd_reg[i] | (LOG_W'(sd_next[i][M_W]) << (FRAC_BITS - 1 - i));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mn_reg[0] <= mn_next;
            md_reg[0] <= md_next;
            rn_reg[0] <= {pn_next, {FRAC_BITS{1'b0}}};
            rd_reg[0] <= {pd_next, {FRAC_BITS{1'b0}}};
            for (int i = 0; i < NL; i++) begin
                mn_reg[i+1] <= sn_next[i][M_W-1:0];
                md_reg[i+1] <= sd_next[i][M_W-1:0];
                rn_reg[i+1] <= rn_next[i];
                rd_reg[i+1] <= rd_next[i];
            end
        end
    end

    // log difference, sign kept apart
    logic [LOG_W:0]   d_next, dneg_next;
    logic [LOG_W-1:0] mag_next, mag_reg;
    logic             neg_reg, neg_l_reg;

    always_comb begin
        d_next    = {1'b0, rn_reg[NL]} - {1'b0, rd_reg[NL]};
        dneg_next = -d_next;
        mag_next  = d_next[LOG_W] ? dneg_next[LOG_W-1:0] : d_next[LOG_W-1:0];
    end

    // natural log: |D| * ln2 in Q32, truncated
    logic [63:0]      lprod_next;
    logic [LOG_W-1:0] lnq_reg;

    assign lprod_next = 64'(mag_reg) * 64'(LN2_Q32);

    // denominator of the Beta equation
    logic [DEN_W-1:0] tprod_next;
    logic [DEN_W:0]   ds_next;
    logic [DEN_W-1:0] den_reg;
    logic             sat_reg;

    always_comb begin
        tprod_next = DEN_W'(lnq_reg) * DEN_W'(T0_HUND);
        if (neg_l_reg) begin
            ds_next = {1'b0, BASE_DEN} - {1'b0, tprod_next};
        end else begin
            ds_next = {1'b0, BASE_DEN} + {1'b0, tprod_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg   <= mag_next;
            neg_reg   <= d_next[LOG_W];
            lnq_reg   <= lprod_next[32 +: LOG_W];
            neg_l_reg <= neg_reg;
            den_reg   <= ds_next[DEN_W-1:0];
            sat_reg   <= ds_next[DEN_W] || (ds_next == '0);
        end
    end

    // rounded dividend, then restoring division one quotient bit per stage
    logic [N_W-1:0]   n_next;
    logic [DEN_W-1:0] dr_rem  [0:Q_W];
    logic [Q_W-1:0]   dr_nlow [0:Q_W];
    logic [DEN_W-1:0] dr_den  [0:Q_W];
    logic [Q_W-1:0]   dr_q    [0:Q_W];
    logic             dr_sat  [0:Q_W];
    logic [DEN_W:0]   trial_next [0:Q_W-1];
    logic             ge_next    [0:Q_W-1];
    logic [DEN_W:0]   diff_next  [0:Q_W-1];

    assign n_next = NUMER + N_W'(den_reg >> 1);

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            trial_next[k] = {dr_rem[k], dr_nlow[k][Q_W-1-k]};
            ge_next[k]    = trial_next[k] >= {1'b0, dr_den[k]};
            diff_next[k]  = trial_next[k] - {1'b0, dr_den[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dr_rem[0]  <= DEN_W'(n_next[N_W-1:Q_W]);
            dr_nlow[0] <= n_next[Q_W-1:0];
            dr_den[0]  <= den_reg;
            dr_q[0]    <= '0;
            dr_sat[0]  <= sat_reg;
            for (int k = 0; k < Q_W; k++) begin
                dr_rem[k+1]  <= ge_next[k] ? diff_next[k][DEN_W-1:0]
                                           : trial_next[k][DEN_W-1:0];
                dr_nlow[k+1] <= dr_nlow[k];
                dr_den[k+1]  <= dr_den[k];
                dr_q[k+1]    <= dr_q[k] | (Q_W'(ge_next[k]) << (Q_W - 1 - k));
                // quotient too wide for the divider: saturate
                dr_sat[k+1]  <= dr_sat[k] || ((k == 0) && (dr_rem[k] >= dr_den[k]));
            end
        end
    end

    // kelvin to Celsius, special cases and clamp
    logic signed [Q_W:0]    t_next;
    logic [TEMP_W-1:0]      temp_next, temp_reg;

    always_comb begin
        t_next = $signed({1'b0, dr_q[Q_W]}) - (Q_W+1)'(KELVIN_OFFSET);
        if (side_reg[LAT-2][LEVEL_W]) begin
            temp_next = TEMP_ZERO_K;
        end else if (dr_sat[Q_W] || (t_next > (Q_W+1)'(TEMP_SAT_HI))) begin
            temp_next = TEMP_SAT_HI;
        end else begin
            temp_next = t_next[TEMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg <= temp_next;
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign temp_out  = temp_reg;
    assign tag_out   = side_reg[LAT-1][LEVEL_W-1:0];

endmodule

// ----- design/thermistor_range_rgb_driver_unit.sv -----
// Throughput: one beat per cycle; the log2 squaring chain (28 stages) and the
// restoring divider (18 stages) are fully pipelined, so only m_ready stalls it.
// Reset (aresetn low, synchronous) empties the pipeline and output register
// and returns all six limits to their reset values; the limit row lives in a
// one-entry RAM behind a valid flag, so no clearing pass is needed.
module thermistor_range_rgb_driver_unit #(
    parameter int SAMPLE_BITS = trrgb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [SAMPLE_BITS-1:0]        s_thermistor_sample,
    input  logic [SAMPLE_BITS-1:0]        s_knob_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [trrgb_pkg::TEMP_W-1:0]  m_temperature,
    output logic [trrgb_pkg::LEVEL_W-1:0] m_red_level,
    output logic [trrgb_pkg::LEVEL_W-1:0] m_green_level,
    output logic [trrgb_pkg::LEVEL_W-1:0] m_blue_level,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trrgb_pkg::APB_AW-1:0]  paddr,
    input  logic [trrgb_pkg::DATA_W-1:0]  pwdata,
    output logic [trrgb_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import trrgb_pkg::*;

    function automatic logic lit_of(input logic [TEMP_W-1:0] t,
                                    input logic [CFG_W-1:0]  lo,
                                    input logic [CFG_W-1:0]  hi);
        logic signed [TEMP_W-1:0] lo_x, hi_x;
        lo_x = $signed({{(TEMP_W-CFG_W){lo[CFG_W-1]}}, lo});
        hi_x = $signed({{(TEMP_W-CFG_W){hi[CFG_W-1]}}, hi});
        return ($signed(t) >= lo_x) && ($signed(t) <= hi_x);
    endfunction

    cfg_row_t          limits;
    logic              adv;
    logic              tp_valid;
    logic [TEMP_W-1:0] tp_temp;
    logic [LEVEL_W-1:0] tp_level;

    logic               m_valid_reg, m_valid_next;
    logic [TEMP_W-1:0]  temp_reg;
    logic [LEVEL_W-1:0] red_reg, green_reg, blue_reg;
    logic [LEVEL_W-1:0] red_next, green_next, blue_next;

    // configuration registers
    trrgb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .limits  (limits)
    );

    assign pready = 1'b1;

    // pipeline moves unless a finished result would overrun a held output
    assign adv     = !(tp_valid && m_valid_reg && !m_ready);
    assign s_ready = adv;

    trrgb_temp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid && adv),
        .raw       (s_thermistor_sample),
        .tag_in    (s_knob_sample[SAMPLE_BITS-1 -: LEVEL_W]),
        .out_valid (tp_valid),
        .temp_out  (tp_temp),
        .tag_out   (tp_level)
    );

    // range check per colour
    always_comb begin
        red_next   = lit_of(tp_temp, limits[REG_RED_MIN], limits[REG_RED_MAX])
                     ? tp_level : '0;
        green_next = lit_of(tp_temp, limits[REG_GREEN_MIN], limits[REG_GREEN_MAX])
                     ? tp_level : '0;
        blue_next  = lit_of(tp_temp, limits[REG_BLUE_MIN], limits[REG_BLUE_MAX])
                     ? tp_level : '0;
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (tp_valid && adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tp_valid && adv) begin
            temp_reg  <= tp_temp;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_temperature = temp_reg;
    assign m_red_level   = red_reg;
    assign m_green_level = green_reg;
    assign m_blue_level  = blue_reg;

endmodule

// ----- design/trrgb_checker.sv -----
module trrgb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [trrgb_pkg::TEMP_W-1:0]  m_temperature,
    input logic [trrgb_pkg::LEVEL_W-1:0] m_red_level,
    input logic [trrgb_pkg::LEVEL_W-1:0] m_green_level,
    input logic [trrgb_pkg::LEVEL_W-1:0] m_blue_level
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // a held result beat stays and keeps its temperature and red level
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature)
                                && $stable(m_red_level))
        else $error("held result beat changed");

    // with the output register empty the input side is never blocked
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // when all three channels are lit they carry the same knob level
    a_same_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_red_level != 0 && m_green_level != 0 && m_blue_level != 0
        |-> m_red_level == m_green_level && m_green_level == m_blue_level)
        else $error("lit channels disagree on level");

    // nothing colder than absolute zero
    a_temp_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $signed(m_temperature) >= -32'sd27315)
        else $error("temperature below absolute zero");

endmodule

bind thermistor_range_rgb_driver_unit trrgb_checker u_trrgb_checker (.*);

// ----- bench/thermistor_range_rgb_driver_unit_tb.sv -----
module thermistor_range_rgb_driver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Block geometry as seen by the bench
    localparam int SAMPLE_W     = 12;
    localparam int FULL_SCALE   = (1 << SAMPLE_W) - 1;
    localparam int LIMIT_COUNT  = trrgb_pkg::CFG_N;
    localparam int UNMAPPED_REG = trrgb_pkg::CFG_N;
    localparam int PIPE_DEPTH   = 52;

    // Beta equation in fixed point: Q28 logs, ln2 in Q32
    localparam int          LOG_FRAC    = 28;
    localparam logic [63:0] LN2_SCALED  = 64'd2977044472;
    localparam longint      BETA        = 4190;
    localparam longint      T0_CENTI    = 29815;
    localparam longint      ZERO_C      = 27315;
    localparam int unsigned OPEN_RATIO  = 10000;
    localparam longint      TEMP_CEIL   = 65535;
    localparam longint      TEMP_FLOOR  = -65536;
    localparam longint      LIMIT_CEIL  = 32767;
    localparam longint      LIMIT_FLOOR = -32768;

    localparam int DIRECTED_N = 14;
    localparam int RANDOM_N   = 385;

    typedef struct {
        logic [16:0] temperature;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } lamp_beat_t;

    // Expected colour levels and temperature for every accepted sample pair
    class lamp_ledger;
        lamp_beat_t pending_lamps[$];
        shortint    limit[LIMIT_COUNT];
        int         faults;

        function new();
            for (int ch = 0; ch < 3; ch++) begin
                limit[2 * ch]     = 100;
                limit[2 * ch + 1] = 0;
            end
            faults = 0;
        endfunction

        function void set_limit(int idx, logic [15:0] v);
            if (idx < LIMIT_COUNT) begin
                limit[idx] = shortint'(v);
            end
        endfunction

        function int pending();
            return pending_lamps.size();
        endfunction

        // log2 of an integer, 28 fraction bits by repeated squaring
        function longint log2_frac(int unsigned x);
            int unsigned p;
            logic [63:0] m;
            longint      r;
            if (x == 0) begin
                return 0;
            end
            p = 0;
            while (p < 31 && (x >> (p + 1)) != 0) begin
                p++;
            end
            r = longint'(p) << LOG_FRAC;
            m = (p <= 30) ? (64'(x) << (30 - p)) : (64'(x) >> (p - 30));
            for (int i = 0; i < LOG_FRAC; i++) begin
                m = (m * m) >> 30;
                if (m >= 64'h8000_0000) begin
                    m = m >> 1;
                    r += longint'(1) << (LOG_FRAC - 1 - i);
                end
            end
            return r;
        endfunction

        // Temperature in hundredths of a degree C for one raw divider count
        function longint beta_temperature(logic [SAMPLE_W-1:0] raw);
            int unsigned num;
            int unsigned den;
            longint      d;
            longint      lnq;
            longint      den100;
            longint      t;
            logic [63:0] mag;
            logic [63:0] numer;
            logic [63:0] kelv;
            bit          neg;
            if (raw == 0) begin
                return -ZERO_C;
            end
            if (raw == FULL_SCALE) begin
                num = OPEN_RATIO;
                den = 1;
            end else begin
                num = raw;
                den = FULL_SCALE - raw;
            end
            d   = log2_frac(num) - log2_frac(den);
            neg = d < 0;
            mag = neg ? 64'(-d) : 64'(d);
            lnq = longint'((mag * LN2_SCALED) >> 32);
            den100 = (100 * BETA) << LOG_FRAC;
            den100 = neg ? den100 - T0_CENTI * lnq : den100 + T0_CENTI * lnq;
            if (den100 <= 0) begin
                return TEMP_CEIL;
            end
            numer = 64'(BETA * T0_CENTI * 100) << LOG_FRAC;
            kelv  = (numer + 64'(den100) / 2) / 64'(den100);
            t = longint'(kelv) - ZERO_C;
            if (t > TEMP_CEIL) t = TEMP_CEIL;
            if (t < TEMP_FLOOR) t = TEMP_FLOOR;
            return t;
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] raw, logic [SAMPLE_W-1:0] knob);
            lamp_beat_t  b;
            longint      t;
            logic [7:0]  level;
            logic [7:0]  lv[3];
            t     = beta_temperature(raw);
            level = knob[SAMPLE_W-1 -: 8];
            for (int ch = 0; ch < 3; ch++) begin
                lv[ch] = (t >= limit[2 * ch] && t <= limit[2 * ch + 1]) ? level : 8'd0;
            end
            b.temperature = t[16:0];
            b.red   = lv[0];
            b.green = lv[1];
            b.blue  = lv[2];
            pending_lamps.push_back(b);
        endfunction

        function void field_check(string name, int expv, int actv);
            if (expv != actv) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expv, actv);
                faults++;
            end
        endfunction

        function void match_result(logic [16:0] temp, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b);
            lamp_beat_t e;
            if (pending_lamps.size() == 0) begin
                $display("%0t: unexpected result beat, temperature %0d", $time,
                         int'($signed(temp)));
                faults++;
                return;
            end
            e = pending_lamps.pop_front();
            field_check("temperature", int'($signed(e.temperature)), int'($signed(temp)));
            field_check("red_level", int'(e.red), int'(r));
            field_check("green_level", int'(e.green), int'(g));
            field_check("blue_level", int'(e.blue), int'(b));
        endfunction
    endclass

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [SAMPLE_W-1:0]        s_thermistor_sample = '0;
    logic [SAMPLE_W-1:0]        s_knob_sample       = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [trrgb_pkg::TEMP_W-1:0]  m_temperature;
    logic [trrgb_pkg::LEVEL_W-1:0] m_red_level;
    logic [trrgb_pkg::LEVEL_W-1:0] m_green_level;
    logic [trrgb_pkg::LEVEL_W-1:0] m_blue_level;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [trrgb_pkg::APB_AW-1:0] paddr  = '0;
    logic [trrgb_pkg::DATA_W-1:0] pwdata = '0;
    logic [trrgb_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    lamp_ledger  book = new();
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int          hold_left     = 0;
    longint      anchor;

    thermistor_range_rgb_driver_unit #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_thermistor_sample(s_thermistor_sample),
        .s_knob_sample      (s_knob_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_temperature      (m_temperature),
        .m_red_level        (m_red_level),
        .m_green_level      (m_green_level),
        .m_blue_level       (m_blue_level),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Beat monitor on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                book.take_sample(s_thermistor_sample, s_knob_sample);
            end
            if (m_valid && m_ready) begin
                book.match_result(m_temperature, m_red_level, m_green_level, m_blue_level);
            end
        end
    end

    function automatic logic [15:0] as_limit(longint t);
        if (t > LIMIT_CEIL) return 16'h7FFF;
        if (t < LIMIT_FLOOR) return 16'h8000;
        return t[15:0];
    endfunction

    task automatic cfg_write(int idx, logic [15:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= trrgb_pkg::APB_AW'(4 * idx);
        pwdata  <= {{16{val[15]}}, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.set_limit(idx, val);
    endtask

    // Read back every limit and compare with the bench copy
    task automatic check_limits();
        logic [15:0] got;
        for (int i = int'(trrgb_pkg::REG_RED_MIN); i <= int'(trrgb_pkg::REG_BLUE_MAX); i++) begin
            @(negedge aclk);
            psel    <= 1'b1;
            pwrite  <= 1'b0;
            penable <= 1'b0;
            paddr   <= trrgb_pkg::APB_AW'(4 * i);
            @(negedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            got = prdata[15:0];
            @(negedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
            book.field_check($sformatf("limit register %0d", i), int'(book.limit[i]),
                             int'($signed(got)));
        end
    endtask

    task automatic program_limits(logic [15:0] rl, logic [15:0] rh, logic [15:0] gl,
                                  logic [15:0] gh, logic [15:0] bl, logic [15:0] bh);
        cfg_write(trrgb_pkg::REG_RED_MIN, rl);
        cfg_write(trrgb_pkg::REG_RED_MAX, rh);
        cfg_write(trrgb_pkg::REG_GREEN_MIN, gl);
        cfg_write(trrgb_pkg::REG_GREEN_MAX, gh);
        cfg_write(trrgb_pkg::REG_BLUE_MIN, bl);
        cfg_write(trrgb_pkg::REG_BLUE_MAX, bh);
        check_limits();
    endtask

    // One sample-pair beat, with an optional idle gap ahead of it
    task automatic send_pair(logic [SAMPLE_W-1:0] raw, logic [SAMPLE_W-1:0] knob);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_thermistor_sample <= raw;
        s_knob_sample       <= knob;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (book.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Limit near some real temperature, nudged so boundaries get hit, or an extreme
    function automatic logic [15:0] random_limit();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) return 16'h8000;
        if (pick < 16) return 16'h7FFF;
        return as_limit(book.beta_temperature(SAMPLE_W'($urandom_range(FULL_SCALE)))
                        + longint'($urandom_range(4)) - 2);
    endfunction

    task automatic random_limits();
        logic [15:0] v[6];
        logic [15:0] tmp;
        for (int ch = 0; ch < 3; ch++) begin
            v[2 * ch]     = random_limit();
            v[2 * ch + 1] = random_limit();
            // mostly ordered so channels light; the rest keep their drawn order
            if ($urandom_range(99) < 75 && $signed(v[2 * ch]) > $signed(v[2 * ch + 1])) begin
                tmp           = v[2 * ch];
                v[2 * ch]     = v[2 * ch + 1];
                v[2 * ch + 1] = tmp;
            end
        end
        program_limits(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_raw();
        if ($urandom_range(99) < 10) begin
            case ($urandom_range(3))
                0: return '0;
                1: return SAMPLE_W'(1);
                2: return SAMPLE_W'(FULL_SCALE - 1);
                default: return SAMPLE_W'(FULL_SCALE);
            endcase
        end
        return SAMPLE_W'($urandom_range(FULL_SCALE));
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] d_raw[DIRECTED_N];
        logic [SAMPLE_W-1:0] d_knob[DIRECTED_N];
        d_raw  = '{12'd0, 12'd1, 12'd2, 12'd4094, 12'd4095, 12'd2047, 12'd2048,
                   12'd2049, 12'hAAA, 12'h555, 12'd1024, 12'd3072, 12'd4095, 12'd0};
        d_knob = '{12'd4095, 12'd0, 12'd15, 12'd16, 12'hAAA, 12'h555, 12'd4095,
                   12'd2048, 12'h555, 12'hAAA, 12'd255, 12'd4080, 12'd4095, 12'd1};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset limits leave every channel dark
        check_limits();
        send_pair(12'd0, 12'd4095);
        send_pair(12'd4095, 12'd4095);
        send_pair(12'd2048, 12'd4095);
        stop_sending();
        drain();

        // Red full span, green exactly one temperature, blue from one above it;
        // a write to an unmapped register must change nothing
        anchor = book.beta_temperature(12'd2048);
        cfg_write(UNMAPPED_REG, 16'h1234);
        program_limits(16'h8000, 16'h7FFF, as_limit(anchor), as_limit(anchor),
                       as_limit(anchor + 1), 16'h7FFF);
        for (int i = 0; i < DIRECTED_N; i++) begin
            send_pair(d_raw[i], d_knob[i]);
        end
        stop_sending();
        drain();

        // Random phases under the four idling regimes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 85; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            if (ph == 3) begin
                // extremes: red dark, green only at the very bottom, blue only at the top
                program_limits(16'h7FFF, 16'h8000, 16'h8000, as_limit(-ZERO_C),
                               16'h7FFF, 16'h7FFF);
            end else begin
                random_limits();
            end
            if (ph == 0) begin
                hold_left = 300;
            end
            for (int i = 0; i < RANDOM_N; i++) begin
                send_pair(random_raw(), SAMPLE_W'($urandom_range(FULL_SCALE)));
            end
            stop_sending();
            drain();
        end

        // Final stretch: nothing stray may follow
        stall_pct = 0;
        repeat (PIPE_DEPTH + 30) @(posedge aclk);
        if (book.faults == 0 && book.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
